// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the allocator unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ffha_pkg.sv =====
`default_nettype none

package ffha_pkg;

    // Store geometry.
    localparam int HEAP_GRANULES   = 65536;
    localparam int ADDR_W          = 16;
    localparam int SIZE_W          = 17;
    localparam int GRANULE_SHIFT   = 4;
    localparam int HEADER_GRANULES = 2;
    localparam int REQ_W           = 24;
    localparam int TOT_W           = 21;

    // Size-class cache.
    localparam int CACHE_CLASSES   = 32;
    localparam int CLS_W           = 5;
    localparam int CACHE_DEPTH     = 16;
    localparam int CNT_W           = 5;

    // Growth step is a power of two.
    localparam int SLACK_SHIFT     = 8;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes.
    localparam logic ST_DONE = 1'b0;
    localparam logic ST_OOM  = 1'b1;

    // Boundary-tag header of one block.
    typedef struct packed {
        logic [SIZE_W-1:0] prev;
        logic [SIZE_W-1:0] size;
        logic              used;
        logic [ADDR_W-1:0] link;
    } t_hdr;

    typedef struct packed {
        logic              operation;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] free_address;
    } t_in;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] address;
    } t_out;

endpackage

`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator_unit.sv =====
// Sequence: a cache hit passes S_ALLOC, S_POP_RD and S_POP_WR to S_FIN; a first-fit search reads and
// checks each header walked; a split writes the remainder header and may rewrite the next header's prev;
// a growth reads the last block, writes the new header and coalesces; a cache eviction scans classes
// downward and pops one block before coalescing. Throughput: one transaction at a time; ready returns
// once the result is registered, and a result still held in the output stalls the sequencer.
// Reset: synchronous active low; clears cache heads, counts, heap end and last block, limit 65536.
`default_nettype none
`include "assert_macros.svh"

module first_fit_heap_allocator_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire ffha_pkg::t_in                     i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output ffha_pkg::t_out                         o_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [ffha_pkg::SIZE_W-1:0]       i_cfg_wdata
);

    localparam int AW = ffha_pkg::ADDR_W;
    localparam int SW = ffha_pkg::SIZE_W;
    localparam int TW = ffha_pkg::TOT_W;
    localparam int CW = ffha_pkg::CLS_W;
    localparam int NW = ffha_pkg::CNT_W;

    typedef enum logic [25:0] {
        S_IDLE      = 26'h0000001,
        S_ALLOC     = 26'h0000002,
        S_POP_RD    = 26'h0000004,
        S_POP_WR    = 26'h0000008,
        S_FF_RD     = 26'h0000010,
        S_FF_CHK    = 26'h0000020,
        S_SPLIT_WR  = 26'h0000040,
        S_SPLIT_NRD = 26'h0000080,
        S_SPLIT_NWR = 26'h0000100,
        S_GR_RD     = 26'h0000200,
        S_GR_CHK    = 26'h0000400,
        S_SCAN      = 26'h0000800,
        S_CO_RD     = 26'h0001000,
        S_CO_B      = 26'h0002000,
        S_CO_NX     = 26'h0004000,
        S_CO_PRD    = 26'h0008000,
        S_CO_PV     = 26'h0010000,
        S_CO_CLR    = 26'h0020000,
        S_CO_NRD    = 26'h0040000,
        S_CO_NWR    = 26'h0080000,
        S_FR_WRD    = 26'h0100000,
        S_FR_WALK   = 26'h0200000,
        S_FR_B      = 26'h0400000,
        S_FR_C      = 26'h0800000,
        S_FR_CL     = 26'h1000000,
        S_FIN       = 26'h2000000
    } t_state;

    // Start of the block after base, or the heap end if none is usable.
    function automatic logic [SW-1:0] next_of(input logic [SW-1:0] base,
                                              input logic [SW-1:0] sz,
                                              input logic [SW-1:0] hend);
        logic [SW:0] sum;
        sum = {1'b0, base} + {1'b0, sz};
        return (sz == '0 || sum > {1'b0, hend}) ? hend : sum[SW-1:0];
    endfunction

    t_state                 r_state;
    ffha_pkg::t_hdr         r_mem [ffha_pkg::HEAP_GRANULES];
    ffha_pkg::t_hdr         r_rdata;
    ffha_pkg::t_hdr         r_hb;
    logic [AW-1:0]          r_heads [ffha_pkg::CACHE_CLASSES];
    logic [NW-1:0]          r_counts [ffha_pkg::CACHE_CLASSES];
    logic [SW-1:0]          r_heap_end;
    logic [AW-1:0]          r_last;
    logic                   r_lbv;
    logic [SW-1:0]          r_limit;
    logic                   r_op;
    logic                   r_small;
    logic                   r_fromgrow;
    logic [TW-1:0]          r_total;
    logic [CW-1:0]          r_cls;
    logic [SW-1:0]          r_p;
    logic [SW-1:0]          r_b;
    logic [SW-1:0]          r_nx;
    logic [SW-1:0]          r_pv;
    logic [SW-1:0]          r_rem;
    logic [AW-1:0]          r_q;
    logic [NW-1:0]          r_k;
    ffha_pkg::t_out         r_res;
    logic                   r_out_valid;
    ffha_pkg::t_out         r_out;

    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    ffha_pkg::t_hdr         w_wdata;
    logic [AW-1:0]          w_raddr;

    // Request size in granules, zero bytes counted as one.
    logic [ffha_pkg::REQ_W-1:0] w_bytes1;
    logic [ffha_pkg::REQ_W:0]   w_bsum;
    logic [TW-1:0]              w_g;
    assign w_bytes1 = (i_in_data.request_bytes == '0) ? ffha_pkg::REQ_W'(1)
                                                      : i_in_data.request_bytes;
    assign w_bsum   = {1'b0, w_bytes1} + (ffha_pkg::REQ_W+1)'(15);
    assign w_g      = w_bsum[ffha_pkg::REQ_W:ffha_pkg::GRANULE_SHIFT];

    // First-fit checks on the header just read.
    logic          w_fit;
    logic [SW-1:0] w_fit_rem;
    logic          w_split;
    logic [SW-1:0] w_p_next;
    assign w_fit     = !r_rdata.used && (TW'(r_rdata.size) >= r_total);
    assign w_fit_rem = r_rdata.size - r_total[SW-1:0];
    assign w_split   = w_fit_rem >= SW'(ffha_pkg::HEADER_GRANULES + 1);
    assign w_p_next  = next_of(r_p, r_rdata.size, r_heap_end);

    // Split bookkeeping.
    logic [SW-1:0] w_b2;
    logic [SW:0]   w_split_n;
    logic          w_last_is_b;
    logic          w_skip_nx;
    assign w_b2        = r_b + r_total[SW-1:0];
    assign w_split_n   = {1'b0, r_b} + {1'b0, r_hb.size};
    assign w_last_is_b = r_lbv && ({1'b0, r_last} == r_b);
    assign w_skip_nx   = w_last_is_b || (r_lbv && ({1'b0, r_last} == w_b2));

    // Growth amount, rounded up to whole slack steps.
    logic [TW-1:0] w_need;
    logic [TW:0]   w_incq;
    logic [TW:0]   w_inc;
    logic [SW-1:0] w_lim;
    logic          w_grow_ok;
    always_comb begin
        w_need = r_total;
        if (r_lbv && !r_rdata.used) begin
            w_need = (TW'(r_rdata.size) < r_total) ? r_total - TW'(r_rdata.size) : '0;
        end
    end
    assign w_incq    = ({1'b0, w_need} + (TW+1)'((1 << ffha_pkg::SLACK_SHIFT) - 1))
                       >> ffha_pkg::SLACK_SHIFT;
    assign w_inc     = w_incq << ffha_pkg::SLACK_SHIFT;
    assign w_lim     = (r_limit > SW'(ffha_pkg::HEAP_GRANULES)) ? SW'(ffha_pkg::HEAP_GRANULES)
                                                                : r_limit;
    assign w_grow_ok = (w_inc != '0) &&
                       ((TW+2)'(r_heap_end) + (TW+2)'(w_inc) <= (TW+2)'(w_lim));

    // Coalescing neighbours of the block just read.
    logic [SW-1:0] w_co_nx;
    logic [SW-1:0] w_co_pv;
    logic [SW-1:0] w_co_merged;
    assign w_co_nx     = next_of(r_b, r_rdata.size, r_heap_end);
    assign w_co_pv     = (r_rdata.prev <= r_b) ? r_b - r_rdata.prev : r_b;
    assign w_co_merged = r_hb.size + r_rdata.size;

    // Cache membership walk and usable size for free.
    logic [AW-1:0] w_q_cur;
    logic [SW-1:0] w_usable;
    assign w_q_cur  = (r_k == '0) ? r_heads[r_cls] : r_q;
    assign w_usable = (r_rdata.size >= SW'(ffha_pkg::HEADER_GRANULES))
                      ? r_rdata.size - SW'(ffha_pkg::HEADER_GRANULES) : '0;

    // Header memory port control.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_b[AW-1:0];
        w_wdata = r_hb;
        w_raddr = r_p[AW-1:0];
        case (r_state)
            S_POP_RD: begin
                w_raddr = r_b[AW-1:0];
            end
            S_POP_WR: begin
                w_we         = 1'b1;
                w_wdata      = r_rdata;
                w_wdata.link = '0;
            end
            S_FF_CHK: begin
                w_we    = w_fit;
                w_waddr = r_p[AW-1:0];
                w_wdata = '{prev: r_rdata.prev,
                            size: w_split ? r_total[SW-1:0] : r_rdata.size,
                            used: 1'b1, link: '0};
            end
            S_SPLIT_WR: begin
                w_we    = 1'b1;
                w_waddr = w_b2[AW-1:0];
                w_wdata = '{prev: r_total[SW-1:0], size: r_rem, used: 1'b0, link: '0};
            end
            S_SPLIT_NRD: begin
                w_raddr = r_nx[AW-1:0];
            end
            S_SPLIT_NWR: begin
                w_we         = 1'b1;
                w_waddr      = r_nx[AW-1:0];
                w_wdata      = r_rdata;
                w_wdata.prev = r_rem;
            end
            S_GR_RD: begin
                w_raddr = r_last;
            end
            S_GR_CHK: begin
                w_we    = w_grow_ok;
                w_waddr = r_heap_end[AW-1:0];
                w_wdata = '{prev: r_lbv ? r_rdata.size : '0, size: w_inc[SW-1:0],
                            used: 1'b1, link: '0};
            end
            S_CO_RD: begin
                w_raddr = r_b[AW-1:0];
            end
            S_CO_B: begin
                w_raddr = w_co_nx[AW-1:0];
            end
            S_CO_NX: begin
                w_we    = !r_rdata.used;
                w_waddr = r_nx[AW-1:0];
                w_wdata = '0;
            end
            S_CO_PRD: begin
                w_raddr = r_pv[AW-1:0];
                w_we    = (r_pv == r_b);
            end
            S_CO_PV: begin
                w_we = 1'b1;
                if (!r_rdata.used) begin
                    w_waddr      = r_pv[AW-1:0];
                    w_wdata      = r_rdata;
                    w_wdata.size = w_co_merged;
                end
            end
            S_CO_CLR: begin
                w_we    = 1'b1;
                w_wdata = '0;
            end
            S_CO_NRD: begin
                w_raddr = r_nx[AW-1:0];
            end
            S_CO_NWR: begin
                w_we         = 1'b1;
                w_waddr      = r_nx[AW-1:0];
                w_wdata      = r_rdata;
                w_wdata.prev = r_hb.size;
            end
            S_FR_WRD: begin
                w_raddr = (r_p < r_heap_end && r_p < r_b) ? r_p[AW-1:0] : r_b[AW-1:0];
            end
            S_FR_C: begin
                w_raddr = w_q_cur;
                w_we    = (r_k >= r_counts[r_cls]) &&
                          (r_counts[r_cls] < NW'(ffha_pkg::CACHE_DEPTH));
                w_wdata.link = r_heads[r_cls];
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Header memory with registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_heap_end  <= '0;
            r_last      <= '0;
            r_lbv       <= 1'b0;
            r_limit     <= SW'(ffha_pkg::HEAP_GRANULES);
            r_out_valid <= 1'b0;
            r_cls       <= '0;
            for (int i = 0; i < ffha_pkg::CACHE_CLASSES; i++) begin
                r_heads[i]  <= '0;
                r_counts[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            // The result register fills when the sequencer finishes and empties on hand-off.
            if (r_state == S_FIN && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op          <= i_in_data.operation;
                        r_total       <= w_g + TW'(ffha_pkg::HEADER_GRANULES);
                        r_small       <= (w_g < TW'(ffha_pkg::CACHE_CLASSES));
                        r_cls         <= w_g[CW-1:0];
                        r_fromgrow    <= 1'b0;
                        r_p           <= '0;
                        r_b           <= SW'(i_in_data.free_address)
                                         - SW'(ffha_pkg::HEADER_GRANULES);
                        r_res         <= '{status: ffha_pkg::ST_DONE, address: '0};
                        if (i_in_data.operation == ffha_pkg::OP_ALLOC) begin
                            r_state <= S_ALLOC;
                        end else if (i_in_data.free_address <
                                     AW'(ffha_pkg::HEADER_GRANULES)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_FR_WRD;
                        end
                    end
                end
                S_ALLOC: begin
                    if (r_small && r_counts[r_cls] != '0) begin
                        r_b     <= SW'(r_heads[r_cls]);
                        r_state <= S_POP_RD;
                    end else begin
                        r_state <= S_FF_RD;
                    end
                end
                S_POP_RD: begin
                    r_state <= S_POP_WR;
                end
                S_POP_WR: begin
                    r_heads[r_cls]  <= r_rdata.link;
                    r_counts[r_cls] <= r_counts[r_cls] - NW'(1);
                    if (r_fromgrow) begin
                        r_state <= S_CO_RD;
                    end else begin
                        r_res.address <= r_b[AW-1:0] + AW'(ffha_pkg::HEADER_GRANULES);
                        r_state       <= S_FIN;
                    end
                end
                S_FF_RD: begin
                    r_state <= (r_p < r_heap_end) ? S_FF_CHK : S_GR_RD;
                end
                S_FF_CHK: begin
                    if (w_fit) begin
                        r_b           <= r_p;
                        r_hb          <= r_rdata;
                        r_rem         <= w_fit_rem;
                        r_res.address <= r_p[AW-1:0] + AW'(ffha_pkg::HEADER_GRANULES);
                        r_state       <= w_split ? S_SPLIT_WR : S_FIN;
                    end else if (r_rdata.size == '0) begin
                        r_state <= S_GR_RD;
                    end else begin
                        r_p     <= w_p_next;
                        r_state <= S_FF_RD;
                    end
                end
                S_SPLIT_WR: begin
                    if (w_last_is_b) begin
                        r_last <= w_b2[AW-1:0];
                    end
                    r_nx <= w_split_n[SW-1:0];
                    if (!w_skip_nx && w_split_n < {1'b0, r_heap_end}) begin
                        r_state <= S_SPLIT_NRD;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_SPLIT_NRD: begin
                    r_state <= S_SPLIT_NWR;
                end
                S_SPLIT_NWR: begin
                    r_state <= S_FIN;
                end
                S_GR_RD: begin
                    r_state <= S_GR_CHK;
                end
                S_GR_CHK: begin
                    if (w_grow_ok) begin
                        r_b        <= r_heap_end;
                        r_heap_end <= r_heap_end + w_inc[SW-1:0];
                        r_state    <= S_CO_RD;
                    end else begin
                        r_cls   <= CW'(ffha_pkg::CACHE_CLASSES - 1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_counts[r_cls] != '0) begin
                        r_b        <= SW'(r_heads[r_cls]);
                        r_fromgrow <= 1'b1;
                        r_state    <= S_POP_RD;
                    end else if (r_cls == CW'(1)) begin
                        r_res.status <= ffha_pkg::ST_OOM;
                        r_state      <= S_FIN;
                    end else begin
                        r_cls <= r_cls - CW'(1);
                    end
                end
                S_CO_RD: begin
                    r_state <= S_CO_B;
                end
                S_CO_B: begin
                    r_hb    <= '{prev: r_rdata.prev, size: r_rdata.size,
                                 used: 1'b0, link: r_rdata.link};
                    r_nx    <= w_co_nx;
                    r_pv    <= w_co_pv;
                    r_state <= (w_co_nx < r_heap_end) ? S_CO_NX : S_CO_PRD;
                end
                S_CO_NX: begin
                    if (!r_rdata.used) begin
                        r_hb.size <= w_co_merged;
                        r_nx      <= next_of(r_b, w_co_merged, r_heap_end);
                    end
                    r_state <= S_CO_PRD;
                end
                S_CO_PRD: begin
                    r_state <= (r_pv != r_b) ? S_CO_PV : S_CO_NRD;
                end
                S_CO_PV: begin
                    if (!r_rdata.used) begin
                        r_hb    <= '{prev: r_rdata.prev, size: w_co_merged,
                                     used: r_rdata.used, link: r_rdata.link};
                        r_state <= S_CO_CLR;
                    end else begin
                        r_state <= S_CO_NRD;
                    end
                end
                S_CO_CLR: begin
                    r_b     <= r_pv;
                    r_state <= S_CO_NRD;
                end
                S_CO_NRD: begin
                    if (r_nx >= r_heap_end) begin
                        r_last <= r_b[AW-1:0];
                        r_lbv  <= 1'b1;
                        r_p    <= '0;
                        r_state <= (r_op == ffha_pkg::OP_FREE) ? S_FIN : S_FF_RD;
                    end else begin
                        r_state <= S_CO_NWR;
                    end
                end
                S_CO_NWR: begin
                    r_p     <= '0;
                    r_state <= (r_op == ffha_pkg::OP_FREE) ? S_FIN : S_FF_RD;
                end
                S_FR_WRD: begin
                    if (r_p < r_heap_end && r_p < r_b) begin
                        r_state <= S_FR_WALK;
                    end else if (r_p != r_b || r_b >= r_heap_end) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_FR_B;
                    end
                end
                S_FR_WALK: begin
                    if (r_rdata.size == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_p     <= w_p_next;
                        r_state <= S_FR_WRD;
                    end
                end
                S_FR_B: begin
                    r_hb  <= r_rdata;
                    r_k   <= '0;
                    r_cls <= w_usable[CW-1:0];
                    if (!r_rdata.used) begin
                        r_state <= S_FIN;
                    end else if (w_usable < SW'(ffha_pkg::CACHE_CLASSES)) begin
                        r_state <= S_FR_C;
                    end else begin
                        r_state <= S_CO_RD;
                    end
                end
                S_FR_C: begin
                    if (r_k < r_counts[r_cls]) begin
                        r_state <= ({1'b0, w_q_cur} == r_b) ? S_FIN : S_FR_CL;
                    end else if (r_counts[r_cls] < NW'(ffha_pkg::CACHE_DEPTH)) begin
                        r_heads[r_cls]  <= r_b[AW-1:0];
                        r_counts[r_cls] <= r_counts[r_cls] + NW'(1);
                        r_state         <= S_FIN;
                    end else begin
                        r_state <= S_CO_RD;
                    end
                end
                S_FR_CL: begin
                    r_q     <= r_rdata.link;
                    r_k     <= r_k + NW'(1);
                    r_state <= S_FR_C;
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks on sequencing and bookkeeping.
    `ASSERT_ALWAYS(a_state_onehot, i_clk, i_rst_n, $onehot(r_state), "state not one-hot")
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")
    `ASSERT_ALWAYS(a_cache_depth, i_clk, i_rst_n, r_counts[r_cls] <= NW'(ffha_pkg::CACHE_DEPTH), "cache count over depth")
    `ASSERT_ALWAYS(a_last_in_heap, i_clk, i_rst_n, !r_lbv || ({1'b0, r_last} < r_heap_end), "last block beyond heap end")

endmodule

`default_nettype wire
